// ----- hw/rtl/c3s_pkg.sv -----
// Shared types and constants for the streaming 3x3 convolution block.
`timescale 1ns / 1ps

package c3s_pkg;

	localparam int KERNEL_SIZE = 3;
	localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
	localparam int GROUPS = KERNEL_TAPS / KERNEL_SIZE;

	localparam int SAMPLE_W = 16;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int GROUP_W = PROD_W + 2;
	localparam int SUM_W = 37;
	localparam int IDX_W = 4;
	localparam int CFG_W = 6;
	localparam int ROW_W = 5;

	localparam logic [CFG_W-1:0] DIM_MIN = 6'd3;
	localparam logic [CFG_W-1:0] ROWS_LIMIT = 6'd32;
	localparam logic [CFG_W-1:0] DIM_RESET = 6'd30;

	typedef enum logic {
		CMD_LOAD_COEF = 1'b0,
		CMD_PIXEL     = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		cmd_t                        command;
		logic [IDX_W-1:0]            coef_index;
		logic signed [SAMPLE_W-1:0]  sample_value;
	} sample_req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] conv_sum;
		logic                    last_of_frame;
	} result_req_t;

	typedef struct packed {
		cfg_reg_t          index;
		logic [CFG_W-1:0]  wdata;
	} cfg_req_t;

endpackage

// ----- hw/rtl/c3s_stream_if.sv -----
// Valid/ready channel carrying one request of a given payload type.
`timescale 1ns / 1ps

interface c3s_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/conv3x3_valid_stream_unit.sv -----
// Streaming valid 3x3 correlation with line buffers, window and pipelined sum.
// Order: a pixel is registered in stage 1, then in the window, products, row sums and result register.
// Throughput: one request per cycle; stages stall only when the result is not taken.
// The line buffer is one memory read at the pixel column; its registered read sets stage one.
// Reset clears stage valids, counters and window, and sets width and height to 30.
// Kernel and line-buffer contents are not cleared and must be written before use.
`timescale 1ns / 1ps

module conv3x3_valid_stream_unit import c3s_pkg::*; #(
	parameter int MAX_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	c3s_stream_if.sink    sample,
	c3s_stream_if.source  result,
	c3s_stream_if.sink    cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int LB_W = 2 * SAMPLE_W;

	// Configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	cfg_req_t         cfg_req;

	assign cfg_req = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_req.index)
				REG_IMAGE_WIDTH: width_q <= cfg_req.wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_req.wdata;
				default: ;
			endcase
		end
	end

	// Clamped frame dimensions
	logic [CMPW-1:0]  width_ext;
	logic [CMPW-1:0]  width_cl;
	logic [CFG_W-1:0] height_cl;

	assign width_ext = CMPW'(width_q);

	always_comb begin
		if (width_ext < CMPW'(DIM_MIN)) begin
			width_cl = CMPW'(DIM_MIN);
		end else if (width_ext > CMPW'(MAX_WIDTH)) begin
			width_cl = CMPW'(MAX_WIDTH);
		end else begin
			width_cl = width_ext;
		end
		if (height_q < DIM_MIN) begin
			height_cl = DIM_MIN;
		end else if (height_q > ROWS_LIMIT) begin
			height_cl = ROWS_LIMIT;
		end else begin
			height_cl = height_q;
		end
	end

	// Position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	sample_req_t      in_req;
	logic             accept;
	logic             accept_pix;
	logic             row_end;
	logic             frame_end;
	logic             emit;

	assign in_req = sample.data;
	assign accept = sample.valid && sample.ready;
	assign accept_pix = accept && (in_req.command == CMD_PIXEL);

	assign row_end = (CMPW'(col_q) + CMPW'(1)) >= width_cl;
	assign frame_end = row_end && ((CFG_W'(row_q) + CFG_W'(1)) >= height_cl);
	assign emit = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept_pix) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1 request fields
	logic                       pix_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic signed [SAMPLE_W-1:0] val_s1;
	logic [CW-1:0]              col_s1;
	logic                       emit_s1;
	logic                       last_s1;

	// Stage handshakes
	logic valid_s1, valid_s2, valid_s3, valid_s4, res_valid_q;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_out;
	logic leave_s1, leave_s2, leave_s3, leave_s4;

	assign ready_out = !res_valid_q || result.ready;
	assign leave_s4 = valid_s4 && ready_out;
	assign ready_s4 = !valid_s4 || ready_out;
	assign leave_s3 = valid_s3 && ready_s4;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign leave_s2 = valid_s2 && ready_s3;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign leave_s1 = valid_s1 && ready_s2;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign sample.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (leave_s1) begin
				valid_s1 <= 1'b0;
			end
			// Only pixels that produce a sum travel past the window stage.
			if (leave_s1) begin
				valid_s2 <= pix_s1 && emit_s1;
			end else if (leave_s2) begin
				valid_s2 <= 1'b0;
			end
			if (leave_s2) begin
				valid_s3 <= 1'b1;
			end else if (leave_s3) begin
				valid_s3 <= 1'b0;
			end
			if (leave_s3) begin
				valid_s4 <= 1'b1;
			end else if (leave_s4) begin
				valid_s4 <= 1'b0;
			end
			if (leave_s4) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1: request fields and line-buffer read
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= (in_req.command == CMD_PIXEL);
			idx_s1 <= in_req.coef_index;
			val_s1 <= in_req.sample_value;
			col_s1 <= col_q;
			emit_s1 <= emit;
			last_s1 <= frame_end;
		end
	end

	// Each word holds the pixel two rows up (high half) and one row up (low half).
	logic [LB_W-1:0] line_mem [MAX_WIDTH];
	logic [LB_W-1:0] line_rd_s1;
	logic signed [SAMPLE_W-1:0] up2_s1;
	logic signed [SAMPLE_W-1:0] up1_s1;

	assign up2_s1 = line_rd_s1[LB_W-1:SAMPLE_W];
	assign up1_s1 = line_rd_s1[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (accept_pix) begin
			line_rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && pix_s1) begin
			line_mem[col_s1] <= {up1_s1, val_s1};
		end
	end

	// Stage 2: window and kernel, updated as a request leaves stage 1
	logic signed [SAMPLE_W-1:0] window_q [KERNEL_TAPS];
	logic signed [SAMPLE_W-1:0] kernel_q [KERNEL_TAPS];
	logic                       last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KERNEL_TAPS; i++) begin
				window_q[i] <= '0;
			end
		end else if (leave_s1 && pix_s1) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
					window_q[r*KERNEL_SIZE+c] <= window_q[r*KERNEL_SIZE+c+1];
				end
			end
			window_q[KERNEL_SIZE-1] <= up2_s1;
			window_q[2*KERNEL_SIZE-1] <= up1_s1;
			window_q[KERNEL_TAPS-1] <= val_s1;
		end
	end

	// A load lands here so that pixels ahead of it still see the old kernel.
	always_ff @(posedge clk) begin
		if (leave_s1 && !pix_s1 && (idx_s1 < IDX_W'(KERNEL_TAPS))) begin
			kernel_q[idx_s1] <= val_s1;
		end
		if (leave_s1) begin
			last_s2 <= last_s1;
		end
	end

	// Stage 3: nine products
	logic signed [PROD_W-1:0] prod_s3 [KERNEL_TAPS];
	logic                     last_s3;

	always_ff @(posedge clk) begin
		if (leave_s2) begin
			for (int i = 0; i < KERNEL_TAPS; i++) begin
				prod_s3[i] <= window_q[i] * kernel_q[i];
			end
			last_s3 <= last_s2;
		end
	end

	// Stage 4: one partial sum per kernel row
	logic signed [GROUP_W-1:0] group_s4 [GROUPS];
	logic                      last_s4;

	always_ff @(posedge clk) begin
		if (leave_s3) begin
			for (int g = 0; g < GROUPS; g++) begin
				group_s4[g] <= GROUP_W'(prod_s3[g*KERNEL_SIZE])
					+ GROUP_W'(prod_s3[g*KERNEL_SIZE+1])
					+ GROUP_W'(prod_s3[g*KERNEL_SIZE+2]);
			end
			last_s4 <= last_s3;
		end
	end

	// Result register
	result_req_t res_q;

	always_ff @(posedge clk) begin
		if (leave_s4) begin
			res_q.conv_sum <= SUM_W'(group_s4[0]) + SUM_W'(group_s4[1])
				+ SUM_W'(group_s4[2]);
			res_q.last_of_frame <= last_s4;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data = res_q;

	// The line-buffer write of the older pixel never hits the column being read.
	a_lb_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(leave_s1 && pix_s1 && accept_pix) |-> (col_s1 != col_q))
		else $error("line buffer read and write hit the same column");

	// The column counter wraps at the end of each row.
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_pix && row_end) |=> (col_q == '0))
		else $error("column counter did not wrap at row end");

	// The row counter restarts after the last pixel of a frame.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_pix && frame_end) |=> (row_q == '0))
		else $error("row counter did not restart at frame end");

	// A result register can only be refilled when its previous request is gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result was overwritten");

endmodule

// ----- test/conv3x3_valid_stream_unit_tb.sv -----
// Self-checking testbench for the streaming 3x3 valid convolution unit.
`timescale 1ns / 1ps

module conv3x3_valid_stream_unit_tb;
	import c3s_pkg::*;

	localparam int LINE_DEPTH = 32;
	localparam int RANDOM_ITEMS = 1750;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int CALM_FROM = 700;
	localparam int CALM_TO = 1000;

	typedef enum logic [1:0] {
		ACT_SAMPLE,
		ACT_CONFIG,
		ACT_SETTLE
	} plan_kind_t;

	typedef struct packed {
		plan_kind_t  kind;
		sample_req_t item;
		cfg_req_t    reg_write;
	} plan_step_t;

	typedef enum logic [1:0] {
		FEED_RUN,
		FEED_SETTLE,
		FEED_WRITE
	} feed_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	c3s_stream_if #(.T(sample_req_t)) sample_ch ();
	c3s_stream_if #(.T(result_req_t)) result_ch ();
	c3s_stream_if #(.T(cfg_req_t))    cfg_ch ();

	logic        px_valid = 1'b0;
	sample_req_t px_data = '0;
	logic        sum_ready = 1'b0;
	logic        reg_valid = 1'b0;
	cfg_req_t    reg_data = '0;

	assign sample_ch.valid = px_valid;
	assign sample_ch.data = px_data;
	assign result_ch.ready = sum_ready;
	assign cfg_ch.valid = reg_valid;
	assign cfg_ch.data = reg_data;

	conv3x3_valid_stream_unit #(
		.MAX_WIDTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// Predictor state; window, counters and sizes mirror what the block holds after reset.
	logic signed [SAMPLE_W-1:0] kern_q [KERNEL_TAPS] = '{default: '0};
	logic signed [SAMPLE_W-1:0] row1_q [LINE_DEPTH] = '{default: '0};
	logic signed [SAMPLE_W-1:0] row2_q [LINE_DEPTH] = '{default: '0};
	logic signed [SAMPLE_W-1:0] win_q [KERNEL_TAPS] = '{default: '0};
	logic [ROW_W-1:0] col_q = '0;
	logic [ROW_W-1:0] row_q = '0;
	logic [CFG_W-1:0] width_q = DIM_RESET;
	logic [CFG_W-1:0] height_q = DIM_RESET;

	// Generator view of the frame position, used to keep line-buffer reads legal.
	logic [ROW_W-1:0] gen_col = '0;
	logic [ROW_W-1:0] gen_row = '0;
	logic [CFG_W-1:0] gen_w = DIM_RESET;
	logic [CFG_W-1:0] gen_h = DIM_RESET;

	plan_step_t  plan_q [$];
	result_req_t sums_due [$];

	feed_state_t feed_state = FEED_RUN;
	int settle_cnt = 0;
	int stall_cycles = 0;
	int errors = 0;
	int items_taken = 0;
	int sums_checked = 0;
	int regs_written = 0;
	int work_items = 0;

	function automatic logic [CFG_W-1:0] span_of(input logic [CFG_W-1:0] raw,
			input logic [CFG_W-1:0] hi);
		if (raw < DIM_MIN)
			return DIM_MIN;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	function automatic void step_counters(inout logic [ROW_W-1:0] col,
			inout logic [ROW_W-1:0] row, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h, output logic row_end, output logic frame_end);
		row_end = {1'b0, col} >= w - 6'd1;
		frame_end = row_end && ({1'b0, row} >= h - 6'd1);
		if (row_end) begin
			col = '0;
			row = frame_end ? '0 : row + 1'b1;
		end else begin
			col = col + 1'b1;
		end
	endfunction

	function automatic void predict_window_sum(input sample_req_t req);
		logic [ROW_W-1:0] col;
		logic signed [SUM_W-1:0] acc;
		logic row_end, frame_end, emit;
		result_req_t due;
		if (req.command == CMD_LOAD_COEF) begin
			if (req.coef_index < KERNEL_TAPS)
				kern_q[req.coef_index] = req.sample_value;
		end else begin
			col = col_q;
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				win_q[r*KERNEL_SIZE] = win_q[r*KERNEL_SIZE+1];
				win_q[r*KERNEL_SIZE+1] = win_q[r*KERNEL_SIZE+2];
			end
			win_q[KERNEL_SIZE-1] = row2_q[col];
			win_q[2*KERNEL_SIZE-1] = row1_q[col];
			win_q[KERNEL_TAPS-1] = req.sample_value;
			row2_q[col] = row1_q[col];
			row1_q[col] = req.sample_value;
			emit = (row_q >= 2) && (col >= 2);
			acc = '0;
			for (int t = 0; t < KERNEL_TAPS; t++)
				acc = acc + win_q[t] * kern_q[t];
			step_counters(col_q, row_q, span_of(width_q, CFG_W'(LINE_DEPTH)),
				span_of(height_q, ROWS_LIMIT), row_end, frame_end);
			if (emit) begin
				due.conv_sum = acc;
				due.last_of_frame = frame_end;
				sums_due.push_back(due);
			end
		end
	endfunction

	function automatic bit take_break();
		if (items_taken >= CALM_FROM && items_taken < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 36;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Stimulus building.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic void push_pixel(input logic signed [SAMPLE_W-1:0] value);
		plan_step_t step;
		logic row_end, frame_end;
		step = '0;
		step.kind = ACT_SAMPLE;
		step.item.command = CMD_PIXEL;
		step.item.coef_index = IDX_W'($urandom_range(15));
		step.item.sample_value = value;
		plan_q.push_back(step);
		step_counters(gen_col, gen_row, span_of(gen_w, CFG_W'(LINE_DEPTH)),
			span_of(gen_h, ROWS_LIMIT), row_end, frame_end);
		work_items++;
	endfunction

	function automatic void push_coef(input logic [IDX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] value);
		plan_step_t step;
		step = '0;
		step.kind = ACT_SAMPLE;
		step.item.command = CMD_LOAD_COEF;
		step.item.coef_index = idx;
		step.item.sample_value = value;
		plan_q.push_back(step);
		if (idx < KERNEL_TAPS)
			work_items++;
	endfunction

	function automatic void push_reg(input cfg_reg_t index, input logic [CFG_W-1:0] value);
		plan_step_t step;
		// A wider row after row zero would read line-buffer columns the row above never wrote.
		if (index == REG_IMAGE_WIDTH && gen_row != 0 &&
				span_of(value, CFG_W'(LINE_DEPTH)) > span_of(gen_w, CFG_W'(LINE_DEPTH)))
			value = gen_w;
		step = '0;
		step.kind = ACT_CONFIG;
		step.reg_write.index = index;
		step.reg_write.wdata = value;
		plan_q.push_back(step);
		if (index == REG_IMAGE_WIDTH)
			gen_w = value;
		else
			gen_h = value;
	endfunction

	function automatic void push_pause();
		plan_step_t step;
		step = '0;
		step.kind = ACT_SETTLE;
		plan_q.push_back(step);
	endfunction

	function automatic void push_noisy_pixel();
		if ($urandom_range(99) < 4)
			push_coef(IDX_W'($urandom_range(15)), pick_sample());
		if ($urandom_range(199) == 0)
			push_pause();
		push_pixel(pick_sample());
	endfunction

	function automatic void finish_frame();
		do
			push_noisy_pixel();
		while (!(gen_col == 0 && gen_row == 0));
	endfunction

	function automatic void pick_dims(output logic [CFG_W-1:0] w, output logic [CFG_W-1:0] h);
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			w = CFG_W'($urandom_range(3, 7));
			h = CFG_W'($urandom_range(3, 7));
		end else if (pick < 72) begin
			w = CFG_W'($urandom_range(32, 63));
			h = CFG_W'($urandom_range(3, 4));
		end else if (pick < 84) begin
			w = CFG_W'($urandom_range(3, 4));
			h = CFG_W'($urandom_range(32, 63));
		end else if (pick < 92) begin
			w = CFG_W'($urandom_range(0, 2));
			h = CFG_W'($urandom_range(0, 6));
		end else begin
			w = CFG_W'($urandom_range(9, 20));
			h = CFG_W'($urandom_range(3, 5));
		end
	endfunction

	// Driver: presents queued requests and feeds the predictor on acceptance.
	always @(posedge clk) begin : feed
		logic next_valid;
		if (arst_n) begin
			if (px_valid && sample_ch.ready) begin
				predict_window_sum(px_data);
				items_taken++;
			end
			if (reg_valid && cfg_ch.ready) begin
				if (reg_data.index == REG_IMAGE_WIDTH)
					width_q = reg_data.wdata;
				else
					height_q = reg_data.wdata;
				regs_written++;
			end
			case (feed_state)
				FEED_RUN: if (!px_valid || sample_ch.ready) begin
					next_valid = 1'b0;
					if (plan_q.size() != 0 && plan_q[0].kind != ACT_SAMPLE) begin
						feed_state <= FEED_SETTLE;
						settle_cnt <= 0;
					end else if (plan_q.size() != 0 && !take_break()) begin
						px_data <= plan_q[0].item;
						plan_q.pop_front();
						next_valid = 1'b1;
					end
					px_valid <= next_valid;
				end
				FEED_SETTLE: begin
					// Pixels that give no sum may still be in flight once the last sum is in.
					if (sums_due.size() != 0) begin
						settle_cnt <= 0;
					end else if (settle_cnt < SETTLE_CYCLES) begin
						settle_cnt <= settle_cnt + 1;
					end else begin
						if (plan_q[0].kind == ACT_CONFIG) begin
							reg_valid <= 1'b1;
							reg_data <= plan_q[0].reg_write;
							feed_state <= FEED_WRITE;
						end else begin
							feed_state <= FEED_RUN;
						end
						plan_q.pop_front();
					end
				end
				FEED_WRITE: if (reg_valid && cfg_ch.ready) begin
					reg_valid <= 1'b0;
					feed_state <= FEED_RUN;
				end
				default: feed_state <= FEED_RUN;
			endcase
		end
	end

	// Monitor: checks each accepted sum against the oldest prediction.
	always @(posedge clk) begin : watch
		result_req_t want;
		result_req_t got;
		if (arst_n) begin
			if (result_ch.valid && sum_ready) begin
				got = result_ch.data;
				if (sums_due.size() == 0) begin
					report_mismatch($sformatf("unexpected sum %0d", got.conv_sum));
				end else begin
					want = sums_due.pop_front();
					if (got.conv_sum !== want.conv_sum)
						report_mismatch($sformatf("conv_sum %0d, predicted %0d",
							got.conv_sum, want.conv_sum));
					if (got.last_of_frame !== want.last_of_frame)
						report_mismatch($sformatf("last_of_frame %0b, predicted %0b",
							got.last_of_frame, want.last_of_frame));
				end
				sums_checked++;
			end
			sum_ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		if ((px_valid && sample_ch.ready) || (result_ch.valid && sum_ready) ||
				(reg_valid && cfg_ch.ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] new_w, new_h;
		int cut;
		int frames;

		// Smallest frame with extreme coefficients and pixels, plus ignored loads.
		push_reg(REG_IMAGE_WIDTH, 6'd3);
		push_reg(REG_IMAGE_HEIGHT, 6'd3);
		push_coef(4'd0, 16'sh8000);
		push_coef(4'd1, 16'sh7FFF);
		push_coef(4'd2, 16'sh8000);
		push_coef(4'd3, 16'sd1);
		push_coef(4'd4, -16'sd1);
		push_coef(4'd5, 16'sd0);
		push_coef(4'd6, 16'sh7FFF);
		push_coef(4'd7, 16'sh8000);
		push_coef(4'd8, 16'sd256);
		push_coef(4'd9, 16'sh7FFF);
		push_coef(4'd15, 16'sh8000);
		push_pixel(16'sh8000);
		push_pixel(16'sh8000);
		push_pixel(16'sh7FFF);
		push_pixel(16'sd0);
		push_pixel(16'sd1);
		push_pixel(-16'sd1);
		push_pixel(16'sh7FFF);
		push_pixel(16'sh8000);
		push_pixel(16'sh8000);
		push_pause();
		// Out-of-range sizes saturate; then a narrower width wraps the column at once.
		push_reg(REG_IMAGE_WIDTH, 6'd63);
		push_reg(REG_IMAGE_HEIGHT, 6'd0);
		push_pixel(pick_sample());
		push_pixel(pick_sample());
		push_pixel(pick_sample());
		push_reg(REG_IMAGE_WIDTH, 6'd3);
		finish_frame();

		while (work_items < RANDOM_ITEMS) begin
			pick_dims(new_w, new_h);
			if ($urandom_range(1)) begin
				push_reg(REG_IMAGE_WIDTH, new_w);
				push_reg(REG_IMAGE_HEIGHT, new_h);
			end else begin
				push_reg(REG_IMAGE_HEIGHT, new_h);
				push_reg(REG_IMAGE_WIDTH, new_w);
			end
			if ($urandom_range(99) < 25) begin
				cut = $urandom_range(1, 3 * span_of(gen_w, CFG_W'(LINE_DEPTH)));
				repeat (cut)
					push_noisy_pixel();
				if ($urandom_range(1))
					push_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, 10)));
				else
					push_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 10)));
				finish_frame();
			end
			frames = $urandom_range(1, 2);
			repeat (frames)
				finish_frame();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || px_valid || feed_state != FEED_RUN)
			@(posedge clk);
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Fed %0d pixel and coefficient requests and %0d register writes;",
			items_taken, regs_written);
		$display("checked %0d sums over frames from 3x3 up to 32 columns or 32 rows.",
			sums_checked);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- conv3x3_valid_stream_unit.f -----
hw/rtl/c3s_pkg.sv
hw/rtl/c3s_stream_if.sv
hw/rtl/conv3x3_valid_stream_unit.sv
test/conv3x3_valid_stream_unit_tb.sv
